FILE: hw/rtl/omni_camera_point_projection_defines.svh
// assertion helpers
`ifndef OMNI_CAMERA_POINT_PROJECTION_DEFINES_SVH
`define OMNI_CAMERA_POINT_PROJECTION_DEFINES_SVH
`define OCP_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define OCP_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

FILE: hw/rtl/ocp_pkg.sv
package ocp_pkg;
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int VW = 54;
  localparam int AW = 36;
  localparam logic signed [AW-1:0] ANG_PI = 36'sd3373259426;
  localparam logic signed [AW-1:0] ANG_HALF_PI = 36'sd1686629713;
  localparam logic signed [31:0] KINV_Q24 = 32'sd10188014;
  localparam logic [2:0] REG_CU = 3'd0;
  localparam logic [2:0] REG_CV = 3'd1;
  localparam logic [2:0] REG_C0 = 3'd2;
  localparam logic [2:0] REG_C1 = 3'd3;
  localparam logic [2:0] REG_C2 = 3'd4;
  localparam logic [2:0] REG_C3 = 3'd5;

  typedef struct packed {
    logic signed [31:0] cu;
    logic signed [31:0] cv;
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] c3;
  } cfg_t;

  function automatic logic signed [AW-1:0] atan_entry(input int i);
    logic signed [AW-1:0] r;
    case (i)
      0: r = 36'sd843314857;
      1: r = 36'sd497837829;
      2: r = 36'sd263043837;
      3: r = 36'sd133525159;
      4: r = 36'sd67021687;
      5: r = 36'sd33543516;
      6: r = 36'sd16775851;
      7: r = 36'sd8388437;
      8: r = 36'sd4194283;
      9: r = 36'sd2097149;
      default: r = (i <= 30) ? (AW'(1) <<< (30 - i)) : '0;
    endcase
    return r;
  endfunction
endpackage

FILE: hw/rtl/ocp_cordic_stage.sv
module ocp_cordic_stage #(
  parameter int STEP = 0,
  parameter bit ROTATE = 1'b0
) (
  input  logic clk,
  input  logic en,
  input  logic signed [ocp_pkg::VW-1:0] x_in,
  input  logic signed [ocp_pkg::VW-1:0] y_in,
  input  logic signed [ocp_pkg::AW-1:0] a_in,
  output logic signed [ocp_pkg::VW-1:0] x_out,
  output logic signed [ocp_pkg::VW-1:0] y_out,
  output logic signed [ocp_pkg::AW-1:0] a_out
);
  import ocp_pkg::*;
  logic pos;
  logic signed [VW-1:0] dx, dy;
  assign pos = ROTATE ? !a_in[AW-1] : !y_in[VW-1];
  assign dx = y_in >>> STEP;
  assign dy = x_in >>> STEP;
  always_ff @(posedge clk) begin
    if (en) begin
      if (ROTATE) begin
        x_out <= pos ? x_in - dx : x_in + dx;
        y_out <= pos ? y_in + dy : y_in - dy;
        a_out <= pos ? a_in - atan_entry(STEP) : a_in + atan_entry(STEP);
      end else begin
        x_out <= pos ? x_in + dx : x_in - dx;
        y_out <= pos ? y_in - dy : y_in + dy;
        a_out <= pos ? a_in + atan_entry(STEP) : a_in - atan_entry(STEP);
      end
    end
  end
endmodule

FILE: hw/rtl/ocp_cordic.sv
module ocp_cordic #(
  parameter int STEPS = ocp_pkg::CORDIC_STEPS_DEF,
  parameter bit ROTATE = 1'b0
) (
  input  logic clk,
  input  logic en,
  input  logic signed [ocp_pkg::VW-1:0] x_in,
  input  logic signed [ocp_pkg::VW-1:0] y_in,
  input  logic signed [ocp_pkg::AW-1:0] a_in,
  output logic signed [ocp_pkg::VW-1:0] x_out,
  output logic signed [ocp_pkg::VW-1:0] y_out,
  output logic signed [ocp_pkg::AW-1:0] a_out
);
  import ocp_pkg::*;
  logic signed [VW-1:0] xs [STEPS+1];
  logic signed [VW-1:0] ys [STEPS+1];
  logic signed [AW-1:0] as [STEPS+1];
  assign xs[0] = x_in;
  assign ys[0] = y_in;
  assign as[0] = a_in;
  for (genvar i = 0; i < STEPS; i++) begin : g_st
    ocp_cordic_stage #(.STEP(i), .ROTATE(ROTATE)) u_st (
      .clk(clk), .en(en), .x_in(xs[i]), .y_in(ys[i]), .a_in(as[i]),
      .x_out(xs[i+1]), .y_out(ys[i+1]), .a_out(as[i+1]));
  end
  assign x_out = xs[STEPS];
  assign y_out = ys[STEPS];
  assign a_out = as[STEPS];
endmodule

FILE: hw/rtl/omni_camera_point_projection.sv
// Omnidirectional camera point projection.
// Slave stream s_axis_*: one 3D point per word (x, y, z in Q16.16, tlast marks
// the last point of a batch). Master stream m_axis_*: one image point per word
// (u, v in Q16.16) with degenerate and saturated flags in tuser, tlast copied.
// Config: cfg_we, cfg_addr, cfg_data write center_u/v and coef_zero..three
// (index 0..5); write only while the pipeline is empty.
// Throughput: one point per cycle unless the receiver stalls; three CORDIC chains
// of CORDIC_STEPS stages (azimuth, elevation, rotation) plus gain, Horner and
// rounding stages, each with at most one 32x32 class multiply.
// Reset clears all valid bits and the config registers.
// When the receiver stalls, the whole pipeline holds (global enable); the
// output register drains first, so s_axis_tready = !out_valid || m_axis_tready.
module omni_camera_point_projection #(
  parameter int CORDIC_STEPS = ocp_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [95:0] s_axis_tdata, // point_x, point_y, point_z
  input  logic s_axis_tlast,        // last_point
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [63:0] m_axis_tdata, // image_u, image_v
  output logic [1:0] m_axis_tuser,  // degenerate_point, saturated
  output logic m_axis_tlast,        // last_result
  input  logic cfg_we,
  input  logic [2:0] cfg_addr,
  input  logic [31:0] cfg_data
);
  import ocp_pkg::*;
  `include "omni_camera_point_projection_defines.svh"

  localparam int DEPTH = 3 * CORDIC_STEPS + 13;
  localparam int PA = 1;
  localparam int PB = PA + CORDIC_STEPS;
  localparam int PC = PB + 2;
  localparam int PD = PC + CORDIC_STEPS;
  localparam int PE = PD + 9;
  localparam int PF = PE + CORDIC_STEPS;

  cfg_t cfg;
  logic en;
  logic [DEPTH-1:0] vld;
  logic [DEPTH-1:0] lst;
  logic [DEPTH-1:0] dgn;
  logic [DEPTH-1:0] zax;
  logic signed [31:0] zq [DEPTH];
  logic signed [AW-1:0] azq [DEPTH];

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CU: cfg.cu <= cfg_data;
        REG_CV: cfg.cv <= cfg_data;
        REG_C0: cfg.c0 <= cfg_data;
        REG_C1: cfg.c1 <= cfg_data;
        REG_C2: cfg.c2 <= cfg_data;
        REG_C3: cfg.c3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: input register and azimuth pre-rotation
  logic signed [31:0] px, py, pz;
  logic signed [VW-1:0] ax0, ay0;
  logic signed [AW-1:0] aa0;
  assign px = s_axis_tdata[31:0];
  assign py = s_axis_tdata[63:32];
  assign pz = s_axis_tdata[95:64];
  always_ff @(posedge clk) begin
    if (en) begin
      ax0 <= px[31] ? -(VW'(px) <<< 4) : (VW'(px) <<< 4);
      ay0 <= px[31] ? -(VW'(py) <<< 4) : (VW'(py) <<< 4);
      aa0 <= px[31] ? (py[31] ? -ANG_PI : ANG_PI) : '0;
      zq[0] <= pz;
      dgn[0] <= (px == 0) && (py == 0) && (pz == 0);
      zax[0] <= (px == 0) && (py == 0);
      lst[0] <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], s_axis_tvalid};
  end

  for (genvar k = 1; k < DEPTH; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        lst[k] <= lst[k-1];
        dgn[k] <= dgn[k-1];
        zax[k] <= zax[k-1];
        zq[k] <= zq[k-1];
      end
    end
  end

  logic signed [VW-1:0] ax1, ay1;
  logic signed [AW-1:0] aa1;
  ocp_cordic #(.STEPS(CORDIC_STEPS), .ROTATE(1'b0)) u_az (
    .clk(clk), .en(en), .x_in(ax0), .y_in(ay0), .a_in(aa0),
    .x_out(ax1), .y_out(ay1), .a_out(aa1));

  // gain on hypot: two stages
  logic [VW+24-1:0] rho_p;
  logic signed [VW-1:0] rho, ez0;
  logic signed [AW-1:0] az_b;
  logic [VW-1:0] ax1_u;
  assign ax1_u = ax1;
  always_ff @(posedge clk) begin
    if (en) begin
      rho_p <= (VW+24)'(ax1_u) * (VW+24)'(KINV_Q24) + (VW+24)'(1 << 23);
      az_b <= aa1;
      rho <= VW'(rho_p >> 24);
      ez0 <= VW'(zq[PB]) <<< 4;
    end
  end
  logic signed [AW-1:0] az_c;
  always_ff @(posedge clk) begin
    if (en) az_c <= az_b;
  end
  assign azq[0] = '0;
  for (genvar k = 1; k < DEPTH; k++) begin : g_az
    if (k == PC - 1) begin : g_ld
      assign azq[k] = az_c;
    end else begin : g_sh
      always_ff @(posedge clk) begin
        if (en) azq[k] <= azq[k-1];
      end
    end
  end

  logic signed [VW-1:0] ex1, ey1;
  logic signed [AW-1:0] el1;
  ocp_cordic #(.STEPS(CORDIC_STEPS), .ROTATE(1'b0)) u_el (
    .clk(clk), .en(en), .x_in(rho), .y_in(ez0), .a_in('0),
    .x_out(ex1), .y_out(ey1), .a_out(el1));

  // Horner: e24, then 3x (mult, round+add), then gain mult, round
  logic signed [AW-1:0] az_s;
  logic signed [AW-7:0] e24;
  logic signed [AW-1:0] el_c;
  assign el_c = zax[PD-1] ? (zq[PD-1][31] ? -ANG_HALF_PI : ANG_HALF_PI) : el1;
  always_ff @(posedge clk) begin
    if (en) begin
      e24 <= (AW-6)'((el_c + AW'(32)) >>> 6);
    end
  end
  // e24 is held across the Horner steps via a small delay line
  logic signed [AW-7:0] e24d [4];
  always_ff @(posedge clk) begin
    if (en) begin
      e24d[0] <= e24;
      for (int k = 1; k < 4; k++) e24d[k] <= e24d[k-1];
    end
  end

  logic signed [65:0] q1, q2, q3;
  logic signed [35:0] b1, b2, b3;
  logic signed [63:0] rp, rq;
  always_ff @(posedge clk) begin
    if (en) begin
      q1 <= 66'(cfg.c3) * 66'(e24);
      b1 <= 36'(cfg.c2) + 36'((q1 + 66'(1 << 23)) >>> 24);
      q2 <= 66'(b1) * 66'(e24d[1]);
      b2 <= 36'(cfg.c1) + 36'((q2 + 66'(1 << 23)) >>> 24);
      q3 <= 66'(b2) * 66'(e24d[3]);
      b3 <= 36'(cfg.c0) + 36'((q3 + 66'(1 << 23)) >>> 24);
      rp <= (64'(b3) <<< 4) * 64'(KINV_Q24);
      rq <= (rp + 64'(1 << 23)) >>> 24;
      az_s <= zax[PE-2] ? '0 : azq[PE-2];
    end
  end

  logic signed [VW-1:0] rx0, ry0;
  logic signed [AW-1:0] ra0;
  logic unused_bits;
  assign unused_bits = ^{ex1, ey1, ay1, zax[DEPTH-1]};
  always_ff @(posedge clk) begin
    if (en) begin
      if (az_s > ANG_HALF_PI) begin
        ra0 <= az_s - ANG_PI;
        rx0 <= -VW'(rq);
      end else if (az_s < -ANG_HALF_PI) begin
        ra0 <= az_s + ANG_PI;
        rx0 <= -VW'(rq);
      end else begin
        ra0 <= az_s;
        rx0 <= VW'(rq);
      end
      ry0 <= '0;
    end
  end

  logic signed [VW-1:0] rx1, ry1;
  logic signed [AW-1:0] ra1;
  ocp_cordic #(.STEPS(CORDIC_STEPS), .ROTATE(1'b1)) u_rot (
    .clk(clk), .en(en), .x_in(rx0), .y_in(ry0), .a_in(ra0),
    .x_out(rx1), .y_out(ry1), .a_out(ra1));

  // output: round, add center, saturate
  logic signed [VW:0] su, sv;
  logic sat_u, sat_v;
  logic dg;
  assign dg = dgn[DEPTH-1];
  always_comb begin
    if (dg) begin
      su = (VW+1)'(cfg.cu) + (VW+1)'(cfg.c0);
      sv = (VW+1)'(cfg.cv);
    end else begin
      su = (VW+1)'(cfg.cu) + (VW+1)'((rx1 + VW'(8)) >>> 4);
      sv = (VW+1)'(cfg.cv) + (VW+1)'((ry1 + VW'(8)) >>> 4);
    end
    sat_u = (su > (VW+1)'(32'sh7fffffff)) || (su < -(VW+1)'(33'sh080000000));
    sat_v = (sv > (VW+1)'(32'sh7fffffff)) || (sv < -(VW+1)'(33'sh080000000));
  end
  logic unused_ra;
  assign unused_ra = ^ra1;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= vld[DEPTH-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata[31:0] <= sat_u ? (su[VW] ? 32'h80000000 : 32'h7fffffff) : su[31:0];
      m_axis_tdata[63:32] <= sat_v ? (sv[VW] ? 32'h80000000 : 32'h7fffffff) : sv[31:0];
      m_axis_tuser <= {sat_u || sat_v, dg};
      m_axis_tlast <= lst[DEPTH-1];
    end
  end

  `OCP_ASSERT(a_ready, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready mismatch")
  `OCP_ASSERT_IMPL(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "lost word")
  `OCP_ASSERT_IMPL(a_fill, en && vld[DEPTH-1], m_axis_tvalid, "valid not forwarded")
endmodule

FILE: verif/omni_camera_point_projection_test.sv
`timescale 1ns / 1ps

module omni_camera_point_projection_test;
  import ocp_pkg::*;

  localparam int STEPS = 24;
  localparam int LATENCY = 3 * STEPS + 13;
  localparam int CYCLE_LIMIT = 600000;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_INV = 64'sd10188014;

  typedef struct packed {
    logic [31:0] u;
    logic [31:0] v;
    logic degen;
    logic sat;
    logic last;
  } image_pt_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic s_axis_tlast;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_we;
  logic [2:0] cfg_addr;
  logic [31:0] cfg_data;

  omni_camera_point_projection u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  longint cam_cfg [6];
  image_pt_t pending_pts [$];
  int errors = 0;
  int cycles = 0;
  int points_sent = 0;
  int points_seen = 0;
  int burst_left = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int ready_mode = 0;
  int mode_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint arctan_q30(int i);
    case (i)
      0: return 843314857;
      1: return 497837829;
      2: return 263043837;
      3: return 133525159;
      4: return 67021687;
      5: return 33543516;
      6: return 16775851;
      7: return 8388437;
      8: return 4194283;
      9: return 2097149;
      default: return (i <= 30) ? (64'sd1 <<< (30 - i)) : 64'sd0;
    endcase
  endfunction

  function automatic longint vector_angle(inout longint vx, inout longint vy, input longint ang);
    longint dx, dy;
    for (int i = 0; i < STEPS; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx += dx; vy -= dy; ang += arctan_q30(i);
      end else begin
        vx -= dx; vy += dy; ang -= arctan_q30(i);
      end
    end
    return ang;
  endfunction

  function automatic longint rnd_q24(longint p);
    return (p + (64'sd1 <<< 23)) >>> 24;
  endfunction

  function automatic longint clip32(longint val, inout logic hit);
    if (val > 64'sd2147483647) begin
      hit = 1'b1; return 64'sd2147483647;
    end
    if (val < -64'sd2147483648) begin
      hit = 1'b1; return -64'sd2147483648;
    end
    return val;
  endfunction

  function automatic image_pt_t project_point(logic [95:0] data, logic lst);
    image_pt_t r;
    longint px, py, pz, az, el, e24, acc, rr, xr, yr, a, vx, vy, rho, vz, dx, dy, uu, vv;
    logic hit;
    px = longint'($signed(data[31:0]));
    py = longint'($signed(data[63:32]));
    pz = longint'($signed(data[95:64]));
    hit = 1'b0;
    r.degen = 1'b0;
    if (px == 0 && py == 0 && pz == 0) begin
      r.degen = 1'b1;
      uu = clip32(cam_cfg[0] + cam_cfg[2], hit);
      vv = clip32(cam_cfg[1], hit);
    end else begin
      if (px == 0 && py == 0) begin
        az = 0;
        el = (pz > 0) ? HALF_PI_Q30 : -HALF_PI_Q30;
      end else begin
        vx = px * 16;
        vy = py * 16;
        a = 0;
        if (vx < 0) begin
          a = (py >= 0) ? PI_Q30 : -PI_Q30;
          vx = -vx; vy = -vy;
        end
        az = vector_angle(vx, vy, a);
        rho = (vx * GAIN_INV + (64'sd1 <<< 23)) >>> 24;
        vz = pz * 16;
        el = vector_angle(rho, vz, 0);
      end
      e24 = (el + 32) >>> 6;
      acc = cam_cfg[5];
      acc = cam_cfg[4] + rnd_q24(acc * e24);
      acc = cam_cfg[3] + rnd_q24(acc * e24);
      acc = cam_cfg[2] + rnd_q24(acc * e24);
      rr = rnd_q24(acc * 16 * GAIN_INV);
      a = az;
      if (a > HALF_PI_Q30) begin
        a -= PI_Q30; rr = -rr;
      end else if (a < -HALF_PI_Q30) begin
        a += PI_Q30; rr = -rr;
      end
      xr = rr;
      yr = 0;
      for (int i = 0; i < STEPS; i++) begin
        dx = yr >>> i;
        dy = xr >>> i;
        if (a >= 0) begin
          xr -= dx; yr += dy; a -= arctan_q30(i);
        end else begin
          xr += dx; yr -= dy; a += arctan_q30(i);
        end
      end
      uu = clip32(cam_cfg[0] + ((xr + 8) >>> 4), hit);
      vv = clip32(cam_cfg[1] + ((yr + 8) >>> 4), hit);
    end
    r.u = uu[31:0];
    r.v = vv[31:0];
    r.sat = hit;
    r.last = lst;
    return r;
  endfunction

  // input monitor: predict every accepted word
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      pending_pts.push_back(project_point(s_axis_tdata, s_axis_tlast));
    end
  end

  // receiver: own stall pattern plus long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 0);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    image_pt_t exp_pt;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      points_seen++;
      if (pending_pts.size() == 0) begin
        $error("unexpected output word u=%h v=%h", m_axis_tdata[31:0], m_axis_tdata[63:32]);
        errors++;
      end else begin
        exp_pt = pending_pts.pop_front();
        if (m_axis_tdata[31:0] !== exp_pt.u) begin
          $error("image_u expected %h actual %h", exp_pt.u, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[63:32] !== exp_pt.v) begin
          $error("image_v expected %h actual %h", exp_pt.v, m_axis_tdata[63:32]);
          errors++;
        end
        if (m_axis_tuser[0] !== exp_pt.degen) begin
          $error("degenerate_point expected %b actual %b", exp_pt.degen, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[1] !== exp_pt.sat) begin
          $error("saturated expected %b actual %b", exp_pt.sat, m_axis_tuser[1]);
          errors++;
        end
        if (m_axis_tlast !== exp_pt.last) begin
          $error("last_result expected %b actual %b", exp_pt.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    s_axis_tlast <= lst;
    do @(posedge clk); while (!s_axis_tready);
    points_sent++;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= REG_C3) cam_cfg[idx] = longint'($signed(val));
  endtask

  task automatic load_config(logic [31:0] cu, cv, c0, c1, c2, c3);
    write_reg(REG_CU, cu);
    write_reg(REG_CV, cv);
    write_reg(REG_C0, c0);
    write_reg(REG_C1, c1);
    write_reg(REG_C2, c2);
    write_reg(REG_C3, c3);
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 6))
      0: return $urandom();
      1: return 32'($signed($urandom()) >>> $urandom_range(8, 24));
      2: return 32'd0;
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom()) >>> $urandom_range(0, 12));
    endcase
  endfunction

  function automatic logic [31:0] rand_coef(int scale);
    return 32'($signed($urandom()) >>> scale);
  endfunction

  task automatic test_reset_config;
    send_point(32'h00010000, 32'h00020000, 32'h00030000, 1'b0);
    send_point(32'd0, 32'd0, 32'd0, 1'b1);
    drain();
  endtask

  task automatic test_directed;
    load_config(32'h01400000, 32'h00f00000, 32'h00c80000, 32'h00640000,
                32'hffe00000, 32'h00080000);
    send_point(32'd0, 32'd0, 32'd0, 1'b0);
    send_point(32'd0, 32'd0, 32'h00010000, 1'b0);
    send_point(32'd0, 32'd0, 32'hffff0000, 1'b0);
    send_point(32'd0, 32'd0, 32'h80000000, 1'b0);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);
    send_point(32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
    send_point(32'h80000000, 32'd0, 32'd0, 1'b0);
    send_point(32'h80000000, 32'hffffffff, 32'd0, 1'b0);
    send_point(32'hffffffff, 32'd0, 32'd1, 1'b0);
    send_point(32'd0, 32'h7fffffff, 32'd0, 1'b0);
    send_point(32'd0, 32'h80000000, 32'd0, 1'b0);
    send_point(32'd1, 32'd0, 32'd0, 1'b0);
    send_point(32'hffff0000, 32'h00010000, 32'h00010000, 1'b0);
    send_point(32'hffff0000, 32'hffff0000, 32'hffff0000, 1'b1);
    drain();
    // saturation of the center and of the radius
    load_config(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff, 32'h7fffffff);
    send_point(32'd0, 32'd0, 32'd0, 1'b0);
    send_point(32'h00010000, 32'd0, 32'd0, 1'b0);
    send_point(32'hffff0000, 32'd0, 32'd0, 1'b0);
    send_point(32'd0, 32'h00010000, 32'h00010000, 1'b1);
    drain();
    load_config(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000,
                32'h80000000, 32'h80000000);
    send_point(32'd0, 32'd0, 32'd0, 1'b0);
    send_point(32'd0, 32'hffff0000, 32'd0, 1'b0);
    send_point(32'h00010000, 32'h00010000, 32'hffff0000, 1'b1);
    // indexes beyond the last register are ignored
    drain();
    write_reg(3'd6, 32'hdeadbeef);
    write_reg(3'd7, 32'h12345678);
    send_point(32'd0, 32'd0, 32'd0, 1'b1);
    drain();
  endtask

  task automatic test_random_projection;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_config(32'h01400000, 32'h00f00000, 32'h00000000, 32'h01000000,
                       32'h00000000, 32'h00000000);
        1: load_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        2: load_config(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h7fffffff, 32'h7fffffff);
        3: load_config(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000000, 32'h80000000);
        default: load_config(rand_coef(4), rand_coef(4), rand_coef(6), rand_coef(7),
                             rand_coef(8), rand_coef(9));
      endcase
      for (int n = 0; n < 300; n++) begin
        send_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 7) == 0);
      end
      drain();
    end
  endtask

  task automatic test_backpressure;
    load_config(32'h01400000, 32'h00f00000, 32'h00640000, 32'h00320000,
                32'h00010000, 32'h00008000);
    hold_req++;
    for (int n = 0; n < 120; n++) begin
      send_point(rand_coord(), rand_coord(), rand_coord(), n == 119);
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    for (int i = 0; i < 6; i++) cam_cfg[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_config();
    test_directed();
    test_backpressure();
    test_random_projection();
    $display("%0d points sent, %0d image points checked over extreme and random settings,",
             points_sent, points_seen);
    $display("including origin, z-axis, saturation and long output stall cases");
    if (errors == 0 && pending_pts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
